// File: rtl/core/fixed_block_pool_allocator_defines.svh
// Assertion macros shared by the block pool allocator RTL
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define FBPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define FBPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/fbpa_pkg.sv
// Shared types and codes for the block pool allocator
package fbpa_pkg;

    localparam int HANDLE_W    = 9;
    localparam int SIZE_W      = 16;
    localparam int ALIGN_W     = 13;
    localparam int STATUS_W    = 3;
    localparam int OFFSET_W    = 25;
    localparam int BYTES_W     = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [STATUS_W-1:0] STATUS_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_OUT_OF_BLOCKS = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_SIZE_MISMATCH = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_ALIGN_MISMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NONE_IN_USE   = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_BAD_HANDLE    = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_ALIGN = 2'd2;

    localparam logic ACTION_ALLOC   = 1'b0;
    localparam logic ACTION_RELEASE = 1'b1;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

// File: rtl/core/fbpa_ctrl.sv
// Controller: request sequencing and result word handshake
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output fbpa_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign s_ready     = (state_reg == ST_IDLE);
    assign cmd.capture = s_valid && s_ready;
    assign cmd.commit  = (state_reg == ST_EXEC) && (!out_valid_reg || m_ready);
    assign m_valid     = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (cmd.commit) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FBPA_ASSERT_NXT(a_capture_to_exec, cmd.capture, state_reg == ST_EXEC, "capture did not enter exec")
    `FBPA_ASSERT_IMP(a_commit_slot_free, cmd.commit, !out_valid_reg || m_ready, "commit over pending word")
    `FBPA_ASSERT_NXT(a_commit_shows_word, cmd.commit, out_valid_reg, "commit did not raise valid")

endmodule

// File: rtl/core/fbpa_dp.sv
// Datapath: configuration, free-list memory, pool counters and result register
`include "fixed_block_pool_allocator_defines.svh"

module fbpa_dp #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fbpa_pkg::cmd_t                      cmd,
    input  logic                                cfg_we,
    input  logic [fbpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_action,
    input  logic [fbpa_pkg::SIZE_W-1:0]         s_requested_size,
    input  logic [fbpa_pkg::ALIGN_W-1:0]        s_requested_align,
    input  logic [fbpa_pkg::HANDLE_W-1:0]       s_release_handle,
    output logic [fbpa_pkg::STATUS_W-1:0]       m_status,
    output logic                                m_null_ignored,
    output logic [fbpa_pkg::HANDLE_W-1:0]       m_granted_handle,
    output logic [fbpa_pkg::OFFSET_W-1:0]       m_byte_offset,
    output logic [fbpa_pkg::HANDLE_W-1:0]       m_blocks_in_use,
    output logic [fbpa_pkg::BYTES_W-1:0]        m_bytes_in_use
);

    localparam int HW        = fbpa_pkg::HANDLE_W;
    localparam int HANDLE_MAX = (1 << HW) - 1;
    localparam int MEM_DEPTH = (NUM_BLOCKS > HANDLE_MAX) ? HANDLE_MAX : NUM_BLOCKS;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int STRIDE_W  = fbpa_pkg::SIZE_W + 1;
    localparam int PROD_W    = HW + STRIDE_W;
    localparam logic [HW-1:0] COUNT_MAX = HW'(MEM_DEPTH);

    logic [HW-1:0]                   count_cfg_reg;
    logic [fbpa_pkg::SIZE_W-1:0]     size_cfg_reg;
    logic [fbpa_pkg::ALIGN_W-1:0]    align_cfg_reg;

    logic                            act_reg;
    logic [fbpa_pkg::SIZE_W-1:0]     rsize_reg;
    logic [fbpa_pkg::ALIGN_W-1:0]    ralign_reg;
    logic [HW-1:0]                   rhandle_reg;

    logic [HW-1:0]                   link_mem [MEM_DEPTH];
    logic [HW-1:0]                   link_rd_reg;

    logic [HW-1:0]                   head_reg, head_next;
    logic [HW-1:0]                   fresh_reg, fresh_next;
    logic [HW-1:0]                   used_reg, used_next;
    logic [fbpa_pkg::BYTES_W-1:0]    bytes_reg, bytes_next;

    logic [fbpa_pkg::STATUS_W-1:0]   out_status_reg;
    logic                            out_null_reg;
    logic [HW-1:0]                   out_handle_reg;
    logic [fbpa_pkg::OFFSET_W-1:0]   out_offset_reg;

    logic [HW-1:0]                   eff_count;
    logic [fbpa_pkg::STATUS_W-1:0]   status_c;
    logic                            null_c;
    logic                            grant_ok;
    logic                            rel_ok;
    logic [HW-1:0]                   grant_idx;
    logic [STRIDE_W-1:0]             stride;
    logic [PROD_W-1:0]               product;
    logic [31:0]                     rd_ext;
    logic [31:0]                     wr_ext;
    logic [ADDR_W-1:0]               rd_addr;
    logic [ADDR_W-1:0]               wr_addr;
    logic [fbpa_pkg::BYTES_W-1:0]    size_ext;

    always_comb begin
        if (count_cfg_reg == '0) begin
            eff_count = HW'(1);
        end else if (count_cfg_reg > COUNT_MAX) begin
            eff_count = COUNT_MAX;
        end else begin
            eff_count = count_cfg_reg;
        end
    end

    assign rd_ext   = {{(32-HW){1'b0}}, head_reg - HW'(1)};
    assign wr_ext   = {{(32-HW){1'b0}}, rhandle_reg - HW'(1)};
    assign rd_addr  = rd_ext[ADDR_W-1:0];
    assign wr_addr  = wr_ext[ADDR_W-1:0];
    assign stride   = {1'b0, size_cfg_reg} + STRIDE_W'(align_cfg_reg);
    assign product  = PROD_W'(grant_idx) * PROD_W'(stride);
    assign size_ext = fbpa_pkg::BYTES_W'(size_cfg_reg);

    always_comb begin
        status_c   = fbpa_pkg::STATUS_OK;
        null_c     = 1'b0;
        grant_ok   = 1'b0;
        rel_ok     = 1'b0;
        grant_idx  = '0;
        head_next  = head_reg;
        fresh_next = fresh_reg;
        used_next  = used_reg;
        bytes_next = bytes_reg;
        if (act_reg == fbpa_pkg::ACTION_ALLOC) begin
            if (rsize_reg != size_cfg_reg) begin
                status_c = fbpa_pkg::STATUS_SIZE_MISMATCH;
            end else if (ralign_reg != align_cfg_reg) begin
                status_c = fbpa_pkg::STATUS_ALIGN_MISMATCH;
            end else if (head_reg != '0) begin
                grant_ok  = 1'b1;
                grant_idx = head_reg - HW'(1);
                head_next = link_rd_reg;
            end else if (fresh_reg < eff_count) begin
                grant_ok   = 1'b1;
                grant_idx  = fresh_reg;
                fresh_next = fresh_reg + HW'(1);
            end else begin
                status_c = fbpa_pkg::STATUS_OUT_OF_BLOCKS;
            end
            if (grant_ok) begin
                used_next  = used_reg + HW'(1);
                bytes_next = bytes_reg + size_ext;
            end
        end else begin
            if (rhandle_reg == '0) begin
                null_c = 1'b1;
            end else if (used_reg == '0) begin
                status_c = fbpa_pkg::STATUS_NONE_IN_USE;
            end else if (rhandle_reg > eff_count) begin
                status_c = fbpa_pkg::STATUS_BAD_HANDLE;
            end else begin
                rel_ok     = 1'b1;
                head_next  = rhandle_reg;
                used_next  = used_reg - HW'(1);
                bytes_next = bytes_reg - size_ext;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_cfg_reg <= HW'(256);
            size_cfg_reg  <= fbpa_pkg::SIZE_W'(64);
            align_cfg_reg <= fbpa_pkg::ALIGN_W'(8);
        end else if (cfg_we) begin
            case (cfg_index)
                fbpa_pkg::CFG_BLOCK_COUNT: count_cfg_reg <= cfg_data[HW-1:0];
                fbpa_pkg::CFG_BLOCK_SIZE:  size_cfg_reg  <= cfg_data[fbpa_pkg::SIZE_W-1:0];
                fbpa_pkg::CFG_BLOCK_ALIGN: align_cfg_reg <= cfg_data[fbpa_pkg::ALIGN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            fresh_reg <= '0;
            used_reg  <= '0;
            bytes_reg <= '0;
        end else if (cmd.commit) begin
            head_reg  <= head_next;
            fresh_reg <= fresh_next;
            used_reg  <= used_next;
            bytes_reg <= bytes_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg     <= s_action;
            rsize_reg   <= s_requested_size;
            ralign_reg  <= s_requested_align;
            rhandle_reg <= s_release_handle;
            link_rd_reg <= link_mem[rd_addr];
        end
        if (cmd.commit && rel_ok) begin
            link_mem[wr_addr] <= head_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_status_reg <= status_c;
            out_null_reg   <= null_c;
            out_handle_reg <= grant_ok ? grant_idx + HW'(1) : '0;
            out_offset_reg <= grant_ok ? product[fbpa_pkg::OFFSET_W-1:0] : '0;
        end
    end

    assign m_status         = out_status_reg;
    assign m_null_ignored   = out_null_reg;
    assign m_granted_handle = out_handle_reg;
    assign m_byte_offset    = out_offset_reg;
    assign m_blocks_in_use  = used_reg;
    assign m_bytes_in_use   = bytes_reg;

    `FBPA_ASSERT_NXT(a_count_holds, !cmd.commit, $stable(used_reg), "use count moved without commit")
    `FBPA_ASSERT_NXT(a_grant_nonnull, cmd.commit && grant_ok, out_handle_reg != '0, "null handle granted")

endmodule

// File: rtl/core/fixed_block_pool_allocator.sv
// Top level of the fixed-size block pool allocator
//
// Request channel s_*: one word per allocate (s_action 0, size and align must
// match the configured block) or release (s_action 1, s_release_handle).
// Result channel m_*: exactly one word per request, in order, carrying status,
// granted handle and byte offset, plus the pool counters after the request.
// Configuration channel cfg_*: index 0 block count, 1 block size, 2 block
// alignment; cfg_ready is always high. Write only while no request is open.
// Each accepted request is registered and applied in the exec state, which
// loads the result word; no new request is taken until it has been applied.
// The free-list pop reads the head link from a registered memory port at
// accept and uses it when applying; s_ready is low while a request is applied.
// If m_ready is low, the result word is held and one more request can be
// accepted; that one waits in the apply step until the word is taken.
// Reset empties the free list and clears all counters and m_valid, and loads
// block count 256, size 64 and alignment 8. No memory clearing is needed.
module fixed_block_pool_allocator #(
    parameter int NUM_BLOCKS = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fbpa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [fbpa_pkg::SIZE_W-1:0]        s_requested_size,
    input  logic [fbpa_pkg::ALIGN_W-1:0]       s_requested_align,
    input  logic [fbpa_pkg::HANDLE_W-1:0]      s_release_handle,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [fbpa_pkg::STATUS_W-1:0]      m_status,
    output logic                               m_null_ignored,
    output logic [fbpa_pkg::HANDLE_W-1:0]      m_granted_handle,
    output logic [fbpa_pkg::OFFSET_W-1:0]      m_byte_offset,
    output logic [fbpa_pkg::HANDLE_W-1:0]      m_blocks_in_use,
    output logic [fbpa_pkg::BYTES_W-1:0]       m_bytes_in_use
);

    fbpa_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    fbpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    fbpa_dp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_action          (s_action),
        .s_requested_size  (s_requested_size),
        .s_requested_align (s_requested_align),
        .s_release_handle  (s_release_handle),
        .m_status          (m_status),
        .m_null_ignored    (m_null_ignored),
        .m_granted_handle  (m_granted_handle),
        .m_byte_offset     (m_byte_offset),
        .m_blocks_in_use   (m_blocks_in_use),
        .m_bytes_in_use    (m_bytes_in_use)
    );

endmodule
